// ===== rtl/core/pds_pkg.sv =====
`timescale 1ns / 1ps

package pds_pkg;

  // Field and register widths
  localparam int TICK_W     = 24;
  localparam int STEP_W     = 16;
  localparam int PHASE_W    = 3;
  localparam int PROG_W     = 17;
  localparam int QUOT_W     = 16;
  localparam int EN_W       = 4;
  localparam int CFG_IDX_W  = 8;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;

  // Divider iterations, one quotient bit each
  localparam int DIV_STEPS  = QUOT_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  // Phase codes
  localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
  localparam logic [PHASE_W-1:0] PH_STARTUP = 3'd1;
  localparam logic [PHASE_W-1:0] PH_RUNNING = 3'd2;
  localparam logic [PHASE_W-1:0] PH_CLEANUP = 3'd3;
  localparam logic [PHASE_W-1:0] PH_DONE    = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STARTUP_TICKS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_TICKS     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLEANUP_TICKS = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_ENABLES = 8'd3;

  // Progress of one, Q1.16
  localparam logic [PROG_W-1:0] PROG_ONE = 17'h10000;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;
    logic prep;
    logic div_step;
    logic write;
  } pds_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_div;
    logic out_free;
  } pds_status_t;

endpackage

// ===== rtl/core/pds_ctrl.sv =====
`timescale 1ns / 1ps

module pds_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  pds_pkg::pds_status_t status,
  output pds_pkg::pds_cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_PREP  = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_WRITE = 2'd3;

  logic [1:0]                     state;
  logic [1:0]                     state_next;
  logic [pds_pkg::DIV_CNT_W-1:0]  cnt;
  logic                           cnt_last;

  assign s_tready = (state == ST_IDLE);
  assign cnt_last = (cnt == pds_pkg::DIV_CNT_W'(pds_pkg::DIV_STEPS - 1));

  // Issue commands from the current state
  always_comb begin
    cmd.accept   = (state == ST_IDLE) && s_tvalid;
    cmd.prep     = (state == ST_PREP);
    cmd.div_step = (state == ST_DIV);
    cmd.write    = (state == ST_WRITE) && status.out_free;
  end

  // Sequence one item: accept, prepare, divide if needed, write result
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_PREP;
      end
      ST_PREP: begin
        state_next = status.need_div ? ST_DIV : ST_WRITE;
      end
      ST_DIV: begin
        if (cnt_last) state_next = ST_WRITE;
      end
      ST_WRITE: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_DIV) cnt <= cnt + 1'b1;
      else                 cnt <= '0;
    end
  end

endmodule

// ===== rtl/core/pds_dp.sv =====
`timescale 1ns / 1ps

module pds_dp #(
  parameter int TIME_BITS = 24
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration writes
  input  logic                               cfg_we,
  input  logic [pds_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pds_pkg::TICK_W-1:0]         cfg_data,
  // input item
  input  logic [pds_pkg::STEP_W-1:0]         time_step,
  // result item
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [pds_pkg::PHASE_W-1:0]        current_phase,
  output logic                               phase_entered,
  output logic [pds_pkg::PROG_W-1:0]         progress,
  output logic                               progress_valid,
  // controller link
  input  pds_pkg::pds_cmd_t                  cmd,
  output pds_pkg::pds_status_t               status
);

  localparam int TICK_W = pds_pkg::TICK_W;
  localparam int EW     = (TIME_BITS > TICK_W) ? TIME_BITS : TICK_W;
  localparam int SW     = ((TIME_BITS > pds_pkg::STEP_W) ? TIME_BITS : pds_pkg::STEP_W) + 1;

  // configuration registers
  logic [TICK_W-1:0]             startup_ticks;
  logic [TICK_W-1:0]             run_ticks;
  logic [TICK_W-1:0]             cleanup_ticks;
  logic [pds_pkg::EN_W-1:0]      phase_enables;

  // sequencer state
  logic [pds_pkg::PHASE_W-1:0]   phase;
  logic [TIME_BITS-1:0]          elapsed;

  // per-item work registers
  logic [pds_pkg::STEP_W-1:0]    step;
  logic                          entered;
  logic                          prog_sat;
  logic [TICK_W-1:0]             rem;
  logic [pds_pkg::QUOT_W-1:0]    quot;

  logic [EW-1:0]                 elapsed_x;
  logic                          ge_startup;
  logic                          ge_run;
  logic                          ge_cleanup;
  logic                          sat_now;
  logic [pds_pkg::PHASE_W-1:0]   phase_next;
  logic [TICK_W:0]               rem_shift;
  logic                          rem_ge;
  logic [SW-1:0]                 sum;
  logic [SW-1:0]                 lim;
  logic [TIME_BITS-1:0]          elapsed_sat;
  logic [pds_pkg::PROG_W-1:0]    prog_val;

  assign elapsed_x  = EW'(elapsed);
  assign ge_startup = elapsed_x >= EW'(startup_ticks);
  assign ge_run     = elapsed_x >= EW'(run_ticks);
  assign ge_cleanup = elapsed_x >= EW'(cleanup_ticks);

  // Pick the next phase; a disabled phase falls through to the next test
  always_comb begin
    phase_next = phase;
    case (phase)
      pds_pkg::PH_IDLE: begin
        if (phase_enables[0])      phase_next = pds_pkg::PH_STARTUP;
        else if (phase_enables[1]) phase_next = ge_startup ? pds_pkg::PH_RUNNING : phase;
        else if (phase_enables[2]) phase_next = ge_run ? pds_pkg::PH_CLEANUP : phase;
        else if (phase_enables[3]) phase_next = ge_cleanup ? pds_pkg::PH_DONE : phase;
      end
      pds_pkg::PH_STARTUP: begin
        if (phase_enables[1])      phase_next = ge_startup ? pds_pkg::PH_RUNNING : phase;
        else if (phase_enables[2]) phase_next = ge_run ? pds_pkg::PH_CLEANUP : phase;
        else if (phase_enables[3]) phase_next = ge_cleanup ? pds_pkg::PH_DONE : phase;
      end
      pds_pkg::PH_RUNNING: begin
        if (phase_enables[2])      phase_next = ge_run ? pds_pkg::PH_CLEANUP : phase;
        else if (phase_enables[3]) phase_next = ge_cleanup ? pds_pkg::PH_DONE : phase;
      end
      pds_pkg::PH_CLEANUP: begin
        if (phase_enables[3])      phase_next = ge_cleanup ? pds_pkg::PH_DONE : phase;
      end
      default: phase_next = phase;
    endcase
  end

  // Progress is one with zero run time or elapsed at or past run time
  assign sat_now = (run_ticks == '0) || ge_run;

  // Restoring divide step: one quotient bit per cycle
  assign rem_shift = {rem, 1'b0};
  assign rem_ge    = rem_shift >= {1'b0, run_ticks};

  // Saturating elapsed advance
  assign sum         = SW'(elapsed) + SW'(step);
  assign lim         = SW'({TIME_BITS{1'b1}});
  assign elapsed_sat = (sum > lim) ? elapsed : TIME_BITS'(sum);

  // Progress value for the result
  always_comb begin
    if (phase != pds_pkg::PH_RUNNING) prog_val = '0;
    else if (prog_sat)                prog_val = pds_pkg::PROG_ONE;
    else                              prog_val = {1'b0, quot};
  end

  assign status.need_div = (phase == pds_pkg::PH_RUNNING) && !sat_now;
  assign status.out_free = !out_valid || out_ready;

  // Hold configuration; writes past the register list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      startup_ticks <= '0;
      run_ticks     <= '0;
      cleanup_ticks <= '0;
      phase_enables <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        pds_pkg::REG_STARTUP_TICKS: startup_ticks <= cfg_data;
        pds_pkg::REG_RUN_TICKS:     run_ticks     <= cfg_data;
        pds_pkg::REG_CLEANUP_TICKS: cleanup_ticks <= cfg_data;
        pds_pkg::REG_PHASE_ENABLES: phase_enables <= cfg_data[pds_pkg::EN_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance phase on accept, clearing elapsed on a phase change; advance elapsed on write
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= pds_pkg::PH_IDLE;
      elapsed <= '0;
    end else if (cmd.accept) begin
      phase <= phase_next;
      if (phase_next != phase) elapsed <= '0;
    end else if (cmd.write) begin
      if (sum > lim) elapsed <= {TIME_BITS{1'b1}};
      else           elapsed <= elapsed_sat;
    end
  end

  // Per-item work registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      step    <= time_step;
      entered <= (phase_next != phase);
    end
    if (cmd.prep) begin
      prog_sat <= sat_now;
      rem      <= elapsed_x[TICK_W-1:0];
      quot     <= '0;
    end else if (cmd.div_step) begin
      rem  <= rem_ge ? TICK_W'(rem_shift - {1'b0, run_ticks}) : rem_shift[TICK_W-1:0];
      quot <= {quot[pds_pkg::QUOT_W-2:0], rem_ge};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.write) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      current_phase  <= phase;
      phase_entered  <= entered;
      progress       <= prog_val;
      progress_valid <= (phase == pds_pkg::PH_RUNNING);
    end
  end

endmodule

// ===== rtl/core/phased_delay_sequencer_top.sv =====
`timescale 1ns / 1ps
// Phased delay sequencer.
// Each item on the s_ channel is one time step (time_step ticks). The block
// walks idle -> startup delay -> running -> cleanup delay -> done, gated by
// the phase_enables register, and returns one result item per step on the
// m_ channel: phase after the step, entry flag, and Q1.16 progress while
// running. Registers are written on the cfg_ channel (index 0 startup_ticks,
// 1 run_ticks, 2 cleanup_ticks, 3 phase_enables); write them only while no
// step is in flight. Other indexes are ignored.
// An accepted step passes a prepare state, the divide state when progress
// needs the divide, and a write state into the output register. The restoring
// divider yields one quotient bit per cycle, 16 bits in all. A new step is not
// accepted until the last one is written; s_tready is high only while no step
// is being worked on.
// Reset clears the registers to zero, the phase to idle and elapsed to zero,
// and empties the output register. If the receiver stalls, the finished
// result is held in the output register; the next step is still accepted and
// worked on, and waits for the output register before it is written.
module phased_delay_sequencer_top #(
  parameter int TIME_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  // input steps
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [pds_pkg::IN_DATA_W-1:0]     s_tdata,   // [15:0] time_step
  // results
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [2:0] current_phase, [3] phase_entered, [20:4] progress,
  // [21] progress_valid, [23:22] zero
  output logic [pds_pkg::OUT_DATA_W-1:0]    m_tdata,
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pds_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pds_pkg::TICK_W-1:0]        cfg_data
);

  pds_pkg::pds_cmd_t            cmd;
  pds_pkg::pds_status_t         status;
  logic [pds_pkg::PHASE_W-1:0]  current_phase;
  logic                         phase_entered;
  logic [pds_pkg::PROG_W-1:0]   progress;
  logic                         progress_valid;

  assign cfg_ready = 1'b1;

  // Pack result fields, lowest first
  assign m_tdata = {2'b00, progress_valid, progress, phase_entered, current_phase};

  pds_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  pds_dp #(
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .time_step      (s_tdata),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .current_phase  (current_phase),
    .phase_entered  (phase_entered),
    .progress       (progress),
    .progress_valid (progress_valid),
    .cmd            (cmd),
    .status         (status)
  );

endmodule
